// ===== design/microwire_eeprom_master_core_macros.svh =====
// ---------------------------------------------------------------------------
// microwire eeprom master assertion macros
// concurrent checks that compile away in synthesis
// ---------------------------------------------------------------------------
`ifndef MICROWIRE_EEPROM_MASTER_CORE_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge out of reset
`define MWEM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mwem check failed");

// condition on one edge implies a consequence on the next edge
`define MWEM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mwem check failed");

`else

`define MWEM_ASSERT_ALWAYS(label, cond)
`define MWEM_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== design/mwem_pkg.sv =====
// ---------------------------------------------------------------------------
// mwem_pkg
// shared types and constants of the microwire eeprom master
// ---------------------------------------------------------------------------
package mwem_pkg;

  // device geometry, x8 organization
  localparam int ADDR_BITS  = 11;
  localparam int DATA_BITS  = 8;
  localparam int CMD_BITS   = 3;
  localparam int FRAME_BITS = CMD_BITS + ADDR_BITS + DATA_BITS;
  localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);
  localparam int PEND_BITS  = ADDR_BITS + DATA_BITS;
  localparam int POLL_BITS  = 16;

  localparam logic [POLL_BITS-1:0] POLL_LIMIT_RESET = 16'd2000;

  // request codes
  localparam logic [1:0] OP_READ       = 2'd0;
  localparam logic [1:0] OP_WR_EN      = 2'd1;
  localparam logic [1:0] OP_WRITE_BYTE = 2'd2;
  localparam logic [1:0] OP_WR_DIS     = 2'd3;

  // start bit plus opcode
  localparam logic [CMD_BITS-1:0] CMD_READ  = 3'b110;
  localparam logic [CMD_BITS-1:0] CMD_EXT   = 3'b100;
  localparam logic [CMD_BITS-1:0] CMD_ERASE = 3'b111;
  localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'b101;

  // bits in the short command frame, the full write frame and a data byte
  localparam logic [CNT_BITS-1:0] CMD_FRAME_LEN  = CNT_BITS'(CMD_BITS + ADDR_BITS);
  localparam logic [CNT_BITS-1:0] WRITE_FRAME_LEN = CNT_BITS'(FRAME_BITS);
  localparam logic [CNT_BITS-1:0] BYTE_LEN        = CNT_BITS'(DATA_BITS);

  // one classified tick word, front to back
  typedef struct packed {
    logic                  start;
    logic [1:0]            op;
    logic [FRAME_BITS-1:0] frame;
    logic [PEND_BITS-1:0]  pending;
    logic [7:0]            byte_count;
    logic                  din;
  } tick_word_t;

  // pin levels and status of one tick
  typedef struct packed {
    logic       cs;
    logic       sk;
    logic       so;
    logic       busy;
    logic       rv;
    logic [7:0] rb;
    logic       rl;
    logic       dn;
    logic       to;
  } tick_res_t;

endpackage

// ===== design/mwem_front.sv =====
// ---------------------------------------------------------------------------
// mwem_front
// accepts tick words, builds command frames and queues them for the engine
// ---------------------------------------------------------------------------
module mwem_front import mwem_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 start_req,
  input  logic [1:0]           op,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [7:0]           byte_count,
  input  logic [7:0]           write_data,
  input  logic                 device_data_in,
  output logic                 q_valid,
  output tick_word_t           q_word,
  input  logic                 q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tick_word_t          slots [QUEUE_DEPTH];
  tick_word_t          word_in;
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;
  logic                push;

  // command frame, left aligned so the msb goes out first
  always_comb begin
    word_in            = '0;
    word_in.start      = start_req;
    word_in.op         = op;
    word_in.byte_count = byte_count;
    word_in.din        = device_data_in;
    word_in.pending    = {address, write_data[DATA_BITS-1:0]};
    case (op)
      OP_READ: begin
        word_in.frame = {CMD_READ, address, {DATA_BITS{1'b0}}};
      end
      OP_WR_EN: begin
        word_in.frame = {CMD_EXT, 2'b11, {(ADDR_BITS - 2 + DATA_BITS){1'b0}}};
      end
      OP_WR_DIS: begin
        word_in.frame = {CMD_EXT, {(ADDR_BITS + DATA_BITS){1'b0}}};
      end
      OP_WRITE_BYTE: begin
        word_in.frame = {CMD_ERASE, address, {DATA_BITS{1'b0}}};
      end
      default: begin
        word_in.frame = '0;
      end
    endcase
  end

  // queue handshake
  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_word   = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= word_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/mwem_back.sv =====
// ---------------------------------------------------------------------------
// mwem_back
// bus engine: one step of the microwire sequencer per queued tick word
// ---------------------------------------------------------------------------
module mwem_back import mwem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [POLL_BITS-1:0] cfg_wdata,
  input  logic                 q_valid,
  input  tick_word_t           q_word,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tick_res_t            res
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SEND_LO = 4'd1;
  localparam logic [3:0] PH_SEND_HI = 4'd2;
  localparam logic [3:0] PH_RECV_LO = 4'd3;
  localparam logic [3:0] PH_RECV_HI = 4'd4;
  localparam logic [3:0] PH_GAP     = 4'd5;
  localparam logic [3:0] PH_POLL    = 4'd6;
  localparam logic [3:0] PH_REARM   = 4'd7;
  localparam logic [3:0] PH_END     = 4'd8;

  logic [3:0]            phase, phase_next;
  logic [1:0]            current_op, current_op_next;
  logic [FRAME_BITS-1:0] tx_shift, tx_shift_next;
  logic [CNT_BITS-1:0]   bit_counter, bit_counter_next;
  logic [7:0]            bytes_left, bytes_left_next;
  logic [DATA_BITS-1:0]  rx_shift, rx_shift_next;
  logic [POLL_BITS-1:0]  poll_counter, poll_counter_next;
  logic [PEND_BITS-1:0]  pending_write, pending_write_next;
  logic                  write_stage, write_stage_next;
  logic [POLL_BITS-1:0]  poll_limit;
  logic                  fire;
  tick_res_t             step;
  logic [CNT_BITS-1:0]   cnt_dec;
  logic [DATA_BITS-1:0]  rx_new;
  logic [7:0]            left_dec;

  // one step when a word waits and the output register is free
  assign fire  = q_valid && (!out_valid || !out_stall);
  assign q_pop = fire;

  assign cnt_dec  = (bit_counter != '0) ? bit_counter - 1'b1 : '0;
  assign rx_new   = {rx_shift[DATA_BITS-2:0], q_word.din};
  assign left_dec = bytes_left - 8'd1;

  // sequencer step
  always_comb begin
    phase_next         = phase;
    current_op_next    = current_op;
    tx_shift_next      = tx_shift;
    bit_counter_next   = bit_counter;
    bytes_left_next    = bytes_left;
    rx_shift_next      = rx_shift;
    poll_counter_next  = poll_counter;
    pending_write_next = pending_write;
    write_stage_next   = write_stage;
    step               = '0;
    step.busy          = 1'b1;
    case (phase)
      PH_IDLE: begin
        if (q_word.start) begin
          current_op_next  = q_word.op;
          tx_shift_next    = q_word.frame;
          bit_counter_next = CMD_FRAME_LEN;
          write_stage_next = 1'b0;
          if (q_word.op == OP_READ) begin
            bytes_left_next = q_word.byte_count;
          end
          if (q_word.op == OP_WRITE_BYTE) begin
            pending_write_next = q_word.pending;
          end
          // first clock-low tick goes out with the request
          step.cs    = 1'b1;
          step.so    = q_word.frame[FRAME_BITS-1];
          phase_next = PH_SEND_HI;
        end else begin
          step.busy = 1'b0;
        end
      end
      PH_SEND_LO: begin
        step.cs    = 1'b1;
        step.so    = (bit_counter != '0) && tx_shift[FRAME_BITS-1];
        phase_next = PH_SEND_HI;
      end
      PH_SEND_HI: begin
        step.cs          = 1'b1;
        step.sk          = 1'b1;
        step.so          = (bit_counter != '0) && tx_shift[FRAME_BITS-1];
        tx_shift_next    = tx_shift << 1;
        bit_counter_next = cnt_dec;
        if (cnt_dec != '0) begin
          phase_next = PH_SEND_LO;
        end else if (current_op == OP_READ) begin
          if (bytes_left == 8'd0) begin
            phase_next = PH_END;
          end else begin
            bit_counter_next = BYTE_LEN;
            rx_shift_next    = '0;
            phase_next       = PH_RECV_LO;
          end
        end else if (current_op == OP_WRITE_BYTE) begin
          phase_next = PH_GAP;
        end else begin
          phase_next = PH_END;
        end
      end
      PH_RECV_LO: begin
        step.cs    = 1'b1;
        phase_next = PH_RECV_HI;
      end
      PH_RECV_HI: begin
        step.cs = 1'b1;
        step.sk = 1'b1;
        if (cnt_dec == '0) begin
          step.rv         = 1'b1;
          step.rb         = rx_new[7:0];
          step.rl         = (bytes_left == 8'd1);
          bytes_left_next = left_dec;
          rx_shift_next   = '0;
          if (left_dec == 8'd0) begin
            bit_counter_next = '0;
            phase_next       = PH_END;
          end else begin
            bit_counter_next = BYTE_LEN;
            phase_next       = PH_RECV_LO;
          end
        end else begin
          rx_shift_next    = rx_new;
          bit_counter_next = cnt_dec;
          phase_next       = PH_RECV_LO;
        end
      end
      PH_GAP: begin
        poll_counter_next = '0;
        phase_next        = PH_POLL;
      end
      PH_POLL: begin
        step.cs = 1'b1;
        if (q_word.din) begin
          phase_next = write_stage ? PH_END : PH_REARM;
        end else if (poll_counter >= poll_limit) begin
          step.to    = 1'b1;
          phase_next = write_stage ? PH_END : PH_REARM;
        end else begin
          poll_counter_next = poll_counter + 1'b1;
        end
      end
      PH_REARM: begin
        tx_shift_next    = {CMD_WRITE, pending_write};
        bit_counter_next = WRITE_FRAME_LEN;
        write_stage_next = 1'b1;
        phase_next       = PH_SEND_LO;
      end
      PH_END: begin
        step.dn    = 1'b1;
        phase_next = PH_IDLE;
      end
      default: begin
        step.busy  = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      current_op    <= '0;
      tx_shift      <= '0;
      bit_counter   <= '0;
      bytes_left    <= '0;
      rx_shift      <= '0;
      poll_counter  <= '0;
      pending_write <= '0;
      write_stage   <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      current_op    <= current_op_next;
      tx_shift      <= tx_shift_next;
      bit_counter   <= bit_counter_next;
      bytes_left    <= bytes_left_next;
      rx_shift      <= rx_shift_next;
      poll_counter  <= poll_counter_next;
      pending_write <= pending_write_next;
      write_stage   <= write_stage_next;
    end
  end

  // ready poll limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit <= cfg_wdata;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step;
    end
  end

endmodule

// ===== design/microwire_eeprom_master_core.sv =====
// ---------------------------------------------------------------------------
// microwire_eeprom_master_core
// microwire eeprom master, x8 organization, one half-period tick per word
// ---------------------------------------------------------------------------
// the result word is registered at the same edge that takes its tick word
// throughput: one tick word per cycle while one is queued and the output is free,
// one result word per tick word
// the rate is set by the single-step sequencer, fed from a QUEUE_DEPTH queue
// reset (synchronous): queue and output register empty, sequencer idle,
// ready poll limit back to 2000 ticks
`include "microwire_eeprom_master_core_macros.svh"

module microwire_eeprom_master_core import mwem_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [POLL_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 start_req,
  input  logic [1:0]           op,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [7:0]           byte_count,
  input  logic [7:0]           write_data,
  input  logic                 device_data_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 chip_select,
  output logic                 serial_clock,
  output logic                 serial_out,
  output logic                 busy_res,
  output logic                 read_valid,
  output logic [7:0]           read_byte,
  output logic                 read_last,
  output logic                 done_res,
  output logic                 timed_out
);

  logic       q_valid;
  logic       q_pop;
  tick_word_t q_word;
  tick_res_t  res;

  // front: accept and classify
  mwem_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_req     (start_req),
    .op            (op),
    .address       (address),
    .byte_count    (byte_count),
    .write_data    (write_data),
    .device_data_in(device_data_in),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_pop         (q_pop)
  );

  // back: bus sequencer and output register
  mwem_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res      (res)
  );

  // result word fields
  assign chip_select  = res.cs;
  assign serial_clock = res.sk;
  assign serial_out   = res.so;
  assign busy_res     = res.busy;
  assign read_valid   = res.rv;
  assign read_byte    = res.rb;
  assign read_last    = res.rl;
  assign done_res     = res.dn;
  assign timed_out    = res.to;

  // a queued word with room at the output always yields a result next cycle
  `MWEM_ASSERT_NEXT(a_step_lands, q_valid && !(out_valid && out_stall), out_valid)
  // the serial clock only pulses with the device selected
  `MWEM_ASSERT_ALWAYS(a_clock_selected, !(out_valid && serial_clock) || chip_select)
  // a finished request drops select and is never a poll tick
  `MWEM_ASSERT_ALWAYS(a_done_deselect, !(out_valid && done_res) || (!chip_select && !timed_out))
  // received bytes only while a request runs
  `MWEM_ASSERT_ALWAYS(a_read_busy, !(out_valid && read_valid) || (busy_res && chip_select))

endmodule
